// ----- src/peblu_pkg.sv -----
// Shared types and constants for the pixel exposure / black lift unit.
// Pixel request and result structs, register indexes, and fixed arithmetic constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package peblu_pkg;

	// Channel and register widths
	localparam int CHAN_W    = 8;
	localparam int EV_W      = 10;
	localparam int BLACK_W   = 7;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = EV_W;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_EXPOSURE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BLACK    = 1'b1;

	// Exposure range and the gain ROM index derived from it
	localparam logic signed [EV_W-1:0] EV_LOW  = -10'sd300;
	localparam logic signed [EV_W-1:0] EV_HIGH = 10'sd300;
	localparam int EV_SPAN   = 601;
	localparam int EV_IDX_W  = 10;
	localparam logic [EV_IDX_W-1:0] EV_IDX_ZERO = 10'd300;
	localparam real EV_PER_STOP = 100.0;

	// Black lift: c*(100-b) + 128*b, kept in hundredths
	localparam logic [BLACK_W-1:0] BLACK_MAX = 7'd100;
	localparam int BOFF_W = 14;
	localparam int LIFT_W = 15;

	// Final divide by 100: saturate, then multiply by ceil(2^22/100) and shift
	localparam int QSAT_W = 15;
	localparam logic [QSAT_W-1:0] Q_SAT_LIMIT = 15'd25600;
	localparam int RECIP_W = 16;
	localparam logic [RECIP_W-1:0] RECIP_100 = 16'd41944;
	localparam int DIV_SHIFT = 22;
	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

	// Half of the divisor 100, added before the divide for round half up
	localparam int ROUND_HALF = 50;

	typedef struct packed {
		logic [CHAN_W-1:0] red_in;
		logic [CHAN_W-1:0] green_in;
		logic [CHAN_W-1:0] blue_in;
		logic [CHAN_W-1:0] alpha_in;
	} pix_in_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red_out;
		logic [CHAN_W-1:0] green_out;
		logic [CHAN_W-1:0] blue_out;
		logic [CHAN_W-1:0] alpha_out;
	} pix_out_t;

endpackage

`default_nettype wire

// ----- src/pixel_exposure_black_lift_unit.sv -----
// Top level of the pixel exposure / black lift unit: config registers, gain ROM, 3-stage pipe.
// Depends on peblu_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes one RGBA pixel per clock and returns it with each color channel lifted
// toward the black point and scaled by 2^(ev/100), rounded half up and clamped;
// alpha is copied. Requests pass the registered stages 1, 2 and 3, and a new
// request is taken every cycle while the result side keeps up; each pipe stage
// holds independently, so requests still enter while a result waits if an
// earlier stage is empty. The gain comes from a 601-entry ROM indexed by the
// saturated exposure; in the cycle after an exposure write no request is taken
// while the ROM read refreshes gain_q. Configuration writes are always taken.
module pixel_exposure_black_lift_unit
	import peblu_pkg::*;
#(
	parameter int GAIN_FRAC_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// pixel requests
	input  wire logic                 pix_valid,
	output logic                      pix_ready,
	input  wire pix_in_t              pix,
	// results
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output pix_out_t                  res,
	// configuration writes
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam int GAIN_W = GAIN_FRAC_BITS + 4;
	localparam int NUM_W  = LIFT_W + GAIN_W;
	localparam int Q_W    = NUM_W - GAIN_FRAC_BITS;
	localparam int DIVP_W = QSAT_W + RECIP_W;

	typedef logic [GAIN_W-1:0] gain_tab_t [EV_SPAN];

	// Gain ROM contents: round_half_up(2^(ev/100) * 2^GAIN_FRAC_BITS)
	function automatic gain_tab_t gain_table_build();
		gain_tab_t tab;
		real       r;
		for (int i = 0; i < EV_SPAN; i++) begin
			r = $pow(2.0, real'(i + int'(EV_LOW)) / EV_PER_STOP)
				* $pow(2.0, real'(GAIN_FRAC_BITS));
			tab[i] = GAIN_W'($rtoi($floor(r + 0.5)));
		end
		return tab;
	endfunction

	localparam gain_tab_t GAIN_TAB = gain_table_build();
	localparam logic [NUM_W-1:0] ROUND_ADD = NUM_W'(ROUND_HALF) << GAIN_FRAC_BITS;

	// Configuration state
	logic [EV_IDX_W-1:0] ev_idx_q;
	logic                refresh_q;
	logic [GAIN_W-1:0]   gain_q;
	logic [BLACK_W-1:0]  b_inv_q;
	logic [BOFF_W-1:0]   b_off_q;

	logic                     cfg_wr;
	logic signed [EV_W-1:0]   ev_raw;
	logic signed [EV_W-1:0]   ev_sat;
	logic signed [EV_W:0]     ev_off;
	logic [BLACK_W-1:0]       b_raw;
	logic [BLACK_W-1:0]       b_sat;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// Saturate incoming register values
	always_comb begin
		ev_raw = $signed(cfg_data[EV_W-1:0]);
		if (ev_raw < EV_LOW) begin
			ev_sat = EV_LOW;
		end else if (ev_raw > EV_HIGH) begin
			ev_sat = EV_HIGH;
		end else begin
			ev_sat = ev_raw;
		end
		ev_off = {ev_sat[EV_W-1], ev_sat} - {EV_LOW[EV_W-1], EV_LOW};
		b_raw  = cfg_data[BLACK_W-1:0];
		b_sat  = (b_raw > BLACK_MAX) ? BLACK_MAX : b_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_idx_q  <= EV_IDX_ZERO;
			refresh_q <= 1'b0;
			b_inv_q   <= BLACK_MAX;
			b_off_q   <= '0;
		end else begin
			refresh_q <= 1'b0;
			if (cfg_wr) begin
				unique case (cfg_index)
					REG_EXPOSURE: begin
						ev_idx_q  <= ev_off[EV_IDX_W-1:0];
						refresh_q <= 1'b1;
					end
					REG_BLACK: begin
						b_inv_q <= BLACK_MAX - b_sat;
						b_off_q <= BOFF_W'(b_sat) << 7;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Gain ROM, registered read in the cycle after an exposure write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_W'(1) << GAIN_FRAC_BITS;
		end else if (refresh_q) begin
			gain_q <= GAIN_TAB[ev_idx_q];
		end
	end

	// Pipe control: each stage loads when empty or when its successor moves
	logic v_s1, v_s2, v_s3;
	logic adv_s1, adv_s2, adv_s3;

	assign adv_s3    = !v_s3 || res_ready;
	assign adv_s2    = !v_s2 || adv_s3;
	assign adv_s1    = !v_s1 || adv_s2;
	assign pix_ready = adv_s1 && !refresh_q;
	assign res_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= pix_valid && pix_ready;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Stage 1: black lift per channel, in hundredths
	logic [2:0][CHAN_W-1:0] chan_in;
	logic [2:0][LIFT_W-1:0] lift_d;
	logic [2:0][LIFT_W-1:0] lift_s1;
	logic [CHAN_W-1:0]      alpha_s1;

	assign chan_in = {pix.red_in, pix.green_in, pix.blue_in};

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			lift_d[ch] = LIFT_W'(chan_in[ch] * b_inv_q) + LIFT_W'(b_off_q);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			lift_s1  <= lift_d;
			alpha_s1 <= pix.alpha_in;
		end
	end

	// Stage 2: apply gain, add half the divisor, drop the fraction bits
	logic [2:0][NUM_W-1:0] num_d;
	logic [2:0][Q_W-1:0]   q_s2;
	logic [CHAN_W-1:0]     alpha_s2;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			num_d[ch] = NUM_W'(lift_s1[ch] * gain_q) + ROUND_ADD;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			for (int ch = 0; ch < 3; ch++) begin
				q_s2[ch] <= num_d[ch][NUM_W-1:GAIN_FRAC_BITS];
			end
			alpha_s2 <= alpha_s1;
		end
	end

	// Stage 3: divide by 100 through the reciprocal, clamp to 255
	logic [2:0][DIVP_W-1:0] divp;
	logic [2:0][CHAN_W-1:0] chan_out_d;
	logic [2:0][CHAN_W-1:0] chan_s3;
	logic [CHAN_W-1:0]      alpha_s3;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			divp[ch] = DIVP_W'(q_s2[ch][QSAT_W-1:0] * RECIP_100);
			if (q_s2[ch] >= Q_W'(Q_SAT_LIMIT)) begin
				chan_out_d[ch] = CHAN_MAX;
			end else begin
				chan_out_d[ch] = divp[ch][DIV_SHIFT +: CHAN_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			chan_s3  <= chan_out_d;
			alpha_s3 <= alpha_s2;
		end
	end

	assign res.red_out   = chan_s3[2];
	assign res.green_out = chan_s3[1];
	assign res.blue_out  = chan_s3[0];
	assign res.alpha_out = alpha_s3;

endmodule

`default_nettype wire

// ----- src/peblu_checker.sv -----
// Port-level checks for the pixel exposure / black lift unit, bound to the top level.
// Depends on peblu_pkg and pixel_exposure_black_lift_unit.
`timescale 1ns / 1ps
`default_nettype none

module peblu_checker
	import peblu_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 pix_valid,
	input wire logic                 pix_ready,
	input wire logic                 res_valid,
	input wire logic                 res_ready,
	input wire pix_out_t             res,
	input wire logic                 cfg_valid,
	input wire logic                 cfg_ready,
	input wire logic [CFG_IDX_W-1:0] cfg_index
);

	logic ev_write;

	assign ev_write = cfg_valid && cfg_ready && (cfg_index == REG_EXPOSURE);

	// A waiting result stays up
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped before it was taken");

	// A waiting result keeps its payload
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res))
		else $error("result payload changed while stalled");

	// Exposure write blocks requests for the gain refresh cycle
	a_ev_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		ev_write |=> !pix_ready)
		else $error("request taken during gain refresh");

	// Full rate: with the result side open and no refresh, requests are taken
	a_full_rate: assert property (@(posedge clk) disable iff (!arst_n)
		res_ready && $past(arst_n) && !$past(ev_write) |-> pix_ready)
		else $error("request refused while pipe can advance");

endmodule

bind pixel_exposure_black_lift_unit peblu_checker u_peblu_checker (.*);

`default_nettype wire
